### rtl/scalar_kalman_filter_top_macros.svh
// assertion macros for the scalar kalman filter
`ifndef SCALAR_KALMAN_FILTER_TOP_MACROS_SVH
`define SCALAR_KALMAN_FILTER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skf assertion failed");
// next-cycle implication
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skf assertion failed");
`else
`define SKF_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SKF_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/skf_pkg.sv
// types and constants shared by the scalar kalman filter
`timescale 1ns / 1ps
package skf_pkg;

  localparam int MEAS_W  = 32;          // measurement port width
  localparam int FE_W    = 48;          // filtered estimate port width
  localparam int COV_W   = 32;          // q8.24 covariance and noises
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int GAIN_FB = 24;          // gain fraction bits
  localparam int GAIN_W  = GAIN_FB + 1; // q1.24
  localparam int DEN_W   = COV_W + 1;
  localparam int DIV_STEPS = GAIN_FB;
  localparam int MUL_A_W = 32;
  localparam int PROD_W  = MUL_A_W + GAIN_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int MAGX_W  = GAIN_FB + MUL_A_W;

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FB;
  localparam logic [ACC_W-1:0]  RND_HALF = ACC_W'(1) << (GAIN_FB - 1);

  localparam logic [COV_W-1:0] COV_RESET = 32'd16777216;
  localparam logic [COV_W-1:0] PN_RESET  = 32'd16777;
  localparam logic [COV_W-1:0] MN_RESET  = 32'd16777216;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INIT_EST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COV = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_NOISE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE = 2'd3;

  typedef logic signed [MEAS_W-1:0] meas_t;
  typedef logic signed [FE_W-1:0]   fest_t;
  typedef logic [COV_W-1:0]         cov_t;
  typedef logic [CFG_W-1:0]         cfg_data_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
  typedef logic [GAIN_W-1:0]        gain_t;
  typedef logic [MUL_A_W-1:0]       mul_a_t;
  typedef logic [PROD_W-1:0]        prod_t;

  typedef struct packed {
    logic  done;
    gain_t gain;
  } skf_div_res_t;

endpackage

### rtl/skf_if.sv
// valid/ready channels for measurements and results
`timescale 1ns / 1ps
interface skf_in_if;
  import skf_pkg::*;
  logic  valid;
  logic  ready;
  meas_t measurement;

  modport source (output valid, output measurement, input ready);
  modport sink (input valid, input measurement, output ready);
endinterface

interface skf_out_if;
  import skf_pkg::*;
  logic  valid;
  logic  ready;
  fest_t filtered_estimate;
  cov_t  covariance_out;

  modport source (output valid, output filtered_estimate, output covariance_out, input ready);
  modport sink (input valid, input filtered_estimate, input covariance_out, output ready);
endinterface

### rtl/skf_div.sv
// restoring divider for the gain p1 * 2^24 / (p1 + measurement noise)
`timescale 1ns / 1ps
module skf_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  skf_pkg::cov_t         p1,
  input  skf_pkg::cov_t         mn,
  output skf_pkg::skf_div_res_t res
);
  import skf_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] rem_nxt;
  logic [DEN_W:0]   rem2;
  logic             ge;
  logic             mn_zero;
  gain_t            q_r;
  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;

  assign den     = {1'b0, p1} + {1'b0, mn};
  assign mn_zero = (mn == '0);

  // one quotient bit per step, a zero denominator gives a zero gain
  assign rem2    = {rem_r, 1'b0};
  assign ge      = (den_r != '0) && (rem2 >= {1'b0, den_r});
  assign rem_nxt = ge ? DEN_W'(rem2 - {1'b0, den_r}) : DEN_W'(rem2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // integer bit of the gain is set only when the noise is zero and p1 is not
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= mn_zero ? '0 : {1'b0, p1};
      q_r   <= {{(GAIN_W-1){1'b0}}, mn_zero && (p1 != '0)};
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[GAIN_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.gain = q_r;

endmodule

### rtl/skf_mul.sv
// registered 32 x 25 unsigned multiplier shared by the update steps
`timescale 1ns / 1ps
module skf_mul (
  input  logic            clk,
  input  skf_pkg::mul_a_t a,
  input  skf_pkg::gain_t  b,
  output skf_pkg::prod_t  prod
);
  import skf_pkg::*;

  prod_t prod_nxt;
  prod_t prod_r;

  assign prod_nxt = a * b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

### rtl/scalar_kalman_filter_top.sv
// scalar kalman filter: sequencer, state, configuration and output register
//
//   channel   dir   fields                               handshake
//   in_ch     in    measurement                          valid/ready
//   out_ch    out   filtered_estimate, covariance_out    valid/ready
//   cfg_*     in    cfg_index, cfg_data                  cfg_we, no wait
//
// an item goes from accept to result through these steps:
// the gain divider needs 24 steps plus load and finish, then three passes through
// the shared multiplier and the update. in_ch.ready is high only while idle.
// a finished result may wait in the output register while the next item is accepted;
// the update of that next item stalls until the register is free.
// synchronous reset loads estimate 0, covariance 1.0 and the default noises.
`timescale 1ns / 1ps
`include "scalar_kalman_filter_top_macros.svh"
module scalar_kalman_filter_top #(
  parameter int MEASUREMENT_WIDTH      = 32,
  parameter int ESTIMATE_FRACTION_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  skf_in_if.sink              in_ch,
  skf_out_if.source           out_ch,
  input  logic                cfg_we,
  input  skf_pkg::cfg_idx_t   cfg_index,
  input  skf_pkg::cfg_data_t  cfg_data
);
  import skf_pkg::*;

  localparam int EST_W  = MEASUREMENT_WIDTH + ESTIMATE_FRACTION_BITS;
  localparam int DIFF_W = EST_W + 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DSTART = 3'd1;
  localparam logic [2:0] S_DWAIT  = 3'd2;
  localparam logic [2:0] S_MHI    = 3'd3;
  localparam logic [2:0] S_MLO    = 3'd4;
  localparam logic [2:0] S_MCOV   = 3'd5;
  localparam logic [2:0] S_UPD    = 3'd6;

  logic [2:0]              state_r, state_nxt;
  logic signed [EST_W-1:0] est_r, est_nxt;
  cov_t                    cov_r, cov_nxt;
  cov_t                    pn_r, pn_nxt;
  cov_t                    mn_r, mn_nxt;
  cov_t                    p1_r, p1_nxt;
  logic [EST_W-1:0]        mag_r, mag_nxt;
  logic                    neg_r, neg_nxt;
  gain_t                   k_r, k_nxt;
  logic [ACC_W-1:0]        acc_r, acc_nxt;
  fest_t                   fe_r, fe_nxt;
  cov_t                    cov_out_r, cov_out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    accept;
  logic                    upd_go;
  logic signed [EST_W-1:0] z;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]       mag_full;
  logic [COV_W:0]          pred_sum;
  cov_t                    p1;
  logic [MAGX_W-1:0]       magx;
  mul_a_t                  mul_a;
  gain_t                   mul_b;
  prod_t                   prod;
  logic [ACC_W-1:0]        rnd;
  logic [EST_W-1:0]        delta;
  logic [EST_W-1:0]        est_sum;
  logic signed [EST_W-1:0] est_new;
  fest_t                   fe_new;
  cov_t                    cov_new;
  logic [MEAS_W-MEASUREMENT_WIDTH:0] ie_top;
  logic                    ie_fits;
  logic signed [EST_W-1:0] est_load;
  logic                    div_start;
  skf_div_res_t            div_res;

  assign accept = in_ch.valid && in_ch.ready;

  // measurement into the estimate format, low bits only
  assign z = {in_ch.measurement[MEASUREMENT_WIDTH-1:0], {ESTIMATE_FRACTION_BITS{1'b0}}};
  assign diff = DIFF_W'(z) - DIFF_W'(est_r);
  assign mag_full = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

  // predicted covariance, saturating
  assign pred_sum = {1'b0, cov_r} + {1'b0, pn_r};
  assign p1 = pred_sum[COV_W] ? '1 : pred_sum[COV_W-1:0];

  // initial estimate scaled, then clamped to the estimate range
  assign ie_top   = cfg_data[MEAS_W-1:MEASUREMENT_WIDTH-1];
  assign ie_fits  = (&ie_top) | ~(|ie_top);
  assign est_load = ie_fits ? {cfg_data[MEASUREMENT_WIDTH-1:0], {ESTIMATE_FRACTION_BITS{1'b0}}}
                            : {cfg_data[MEAS_W-1], {(EST_W-1){~cfg_data[MEAS_W-1]}}};

  assign div_start = (state_r == S_DSTART);

  skf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .p1    (p1_r),
    .mn    (mn_r),
    .res   (div_res)
  );

  // delta = (mag >> 24) * k + round((mag & low) * k >> 24)
  assign magx = MAGX_W'(mag_r);

  // covariance operands stay on while the update waits
  always_comb begin
    unique case (state_r) inside
      S_MLO: begin
        mul_a = MUL_A_W'(magx[GAIN_FB-1:0]);
        mul_b = k_r;
      end
      S_MCOV, S_UPD: begin
        mul_a = p1_r;
        mul_b = GAIN_ONE - k_r;
      end
      default: begin
        mul_a = magx[MAGX_W-1:GAIN_FB];
        mul_b = k_r;
      end
    endcase
  end

  skf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign rnd     = (ACC_W'(prod) + RND_HALF) >> GAIN_FB;
  assign delta   = acc_r[EST_W-1:0];
  assign est_sum = neg_r ? (est_r - delta) : (est_r + delta);
  assign est_new = est_sum;
  assign cov_new = rnd[COV_W-1:0];

  generate
    if (EST_W > FE_W) begin : g_sat
      logic [EST_W-FE_W:0] est_top;
      logic                est_fits;
      assign est_top  = est_new[EST_W-1:FE_W-1];
      assign est_fits = (&est_top) | ~(|est_top);
      assign fe_new   = est_fits ? est_new[FE_W-1:0]
                                 : {est_new[EST_W-1], {(FE_W-1){~est_new[EST_W-1]}}};
    end else begin : g_ext
      assign fe_new = FE_W'(est_new);
    end
  endgenerate

  assign upd_go = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    est_nxt       = est_r;
    cov_nxt       = cov_r;
    pn_nxt        = pn_r;
    mn_nxt        = mn_r;
    p1_nxt        = p1_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    fe_nxt        = fe_r;
    cov_out_nxt   = cov_out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          p1_nxt    = p1;
          mag_nxt   = mag_full[EST_W-1:0];
          neg_nxt   = diff[DIFF_W-1];
          state_nxt = S_DSTART;
        end
      end
      S_DSTART: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (div_res.done) begin
          k_nxt     = div_res.gain;
          state_nxt = S_MHI;
        end
      end
      S_MHI: begin
        state_nxt = S_MLO;
      end
      S_MLO: begin
        acc_nxt   = ACC_W'(prod);
        state_nxt = S_MCOV;
      end
      S_MCOV: begin
        acc_nxt   = acc_r + rnd;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (upd_go) begin
          est_nxt       = est_new;
          cov_nxt       = cov_new;
          fe_nxt        = fe_new;
          cov_out_nxt   = cov_new;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        REG_INIT_EST:   est_nxt = est_load;
        REG_INIT_COV:   cov_nxt = cfg_data;
        REG_PROC_NOISE: pn_nxt  = cfg_data;
        REG_MEAS_NOISE: mn_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      est_r       <= '0;
      cov_r       <= COV_RESET;
      pn_r        <= PN_RESET;
      mn_r        <= MN_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      est_r       <= est_nxt;
      cov_r       <= cov_nxt;
      pn_r        <= pn_nxt;
      mn_r        <= mn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r      <= p1_nxt;
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    k_r       <= k_nxt;
    acc_r     <= acc_nxt;
    fe_r      <= fe_nxt;
    cov_out_r <= cov_out_nxt;
  end

  assign in_ch.ready              = (state_r == S_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.filtered_estimate = fe_r;
  assign out_ch.covariance_out    = cov_out_r;

  `SKF_ASSERT_NXT(a_accept_starts_div, clk, rst_n, accept, state_r == S_DSTART)
  `SKF_ASSERT_IMP(a_div_done_in_wait, clk, rst_n, div_res.done, state_r == S_DWAIT)
  `SKF_ASSERT_IMP(a_gain_le_one, clk, rst_n, div_res.done, div_res.gain <= GAIN_ONE)
  `SKF_ASSERT_IMP(a_cov_not_above_pred, clk, rst_n, state_r == S_UPD, cov_new <= p1_r)

endmodule
